// ===== hdl/ifa_pkg.sv =====
// Shared types and constants for the isochronous frame assembler.
package ifa_pkg;

    // Widths fixed by the descriptor and result formats
    localparam int STATUS_W  = 2;
    localparam int PBYTES_W  = 12;
    localparam int HLEN_W    = 8;
    localparam int FILL_W    = 24;
    localparam int EVENT_W   = 3;
    localparam int FEND_W    = 2;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 24;

    // Depth of the queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // USB completion status codes
    localparam logic [STATUS_W-1:0] USB_DONE    = 2'd0;
    localparam logic [STATUS_W-1:0] USB_ERROR   = 2'd1;
    localparam logic [STATUS_W-1:0] USB_SKIPPED = 2'd2;
    localparam logic [STATUS_W-1:0] USB_GONE    = 2'd3;

    // Result event codes
    localparam logic [EVENT_W-1:0] EV_NONE      = 3'd0;
    localparam logic [EVENT_W-1:0] EV_APPEND    = 3'd1;
    localparam logic [EVENT_W-1:0] EV_UNDERFLOW = 3'd2;
    localparam logic [EVENT_W-1:0] EV_OVERFLOW  = 3'd3;
    localparam logic [EVENT_W-1:0] EV_PAUSED    = 3'd4;

    // Frame end codes
    localparam logic [FEND_W-1:0] FE_NONE    = 2'd0;
    localparam logic [FEND_W-1:0] FE_GOOD    = 2'd1;
    localparam logic [FEND_W-1:0] FE_DISCARD = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_STREAM_ENABLE  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_CAPACITY = 1'd1;

    localparam logic [FILL_W-1:0] CAPACITY_RESET = '1;

    // Input descriptor
    typedef struct packed {
        logic [STATUS_W-1:0] usb_status;
        logic [PBYTES_W-1:0] packet_bytes;
        logic [HLEN_W-1:0]   header_length;
        logic                frame_tag;
        logic                error_bit;
        logic                end_bit;
        logic                buffer_free;
    } iso_in_t;

    // Result item
    typedef struct packed {
        logic [EVENT_W-1:0]  event_res;
        logic [FILL_W-1:0]   write_offset;
        logic [PBYTES_W-1:0] write_length;
        logic [HLEN_W-1:0]   data_start;
        logic [FEND_W-1:0]   frame_end;
        logic [FILL_W-1:0]   frame_length;
    } iso_out_t;

    // Packet class decided by the front
    typedef enum logic [1:0] {
        KIND_NOP,
        KIND_ERR,
        KIND_DATA,
        KIND_GONE
    } kind_t;

    // Classified descriptor carried through the queue
    typedef struct packed {
        kind_t               kind;
        logic [PBYTES_W-1:0] payload_len;
        logic [HLEN_W-1:0]   header_length;
        logic                frame_tag;
        logic                error_bit;
        logic                end_bit;
        logic                buffer_free;
    } item_t;

endpackage

// ===== hdl/ifa_front.sv =====
// Front end: accepts descriptors, classifies them and pushes them to the queue.
module ifa_front #(
    parameter int MAX_PACKET_BYTES = 3072
) (
    input  ifa_pkg::iso_in_t s_data,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic             q_full,
    output logic             q_push,
    output ifa_pkg::item_t   q_item
);

    localparam logic [ifa_pkg::PBYTES_W-1:0] MaxBytes =
        ifa_pkg::PBYTES_W'(MAX_PACKET_BYTES);

    logic bad_len;

    // Handshake: take a transaction whenever the queue has room
    assign s_ready = !q_full;
    assign q_push  = s_valid && !q_full;

    // Short packets and oversized packets count as USB errors
    assign bad_len = (s_data.packet_bytes < ifa_pkg::PBYTES_W'(s_data.header_length))
                  || (s_data.packet_bytes > MaxBytes);

    // Classification in priority order of the status checks
    always_comb begin
        q_item.payload_len   = s_data.packet_bytes - ifa_pkg::PBYTES_W'(s_data.header_length);
        q_item.header_length = s_data.header_length;
        q_item.frame_tag     = s_data.frame_tag;
        q_item.error_bit     = s_data.error_bit;
        q_item.end_bit       = s_data.end_bit;
        q_item.buffer_free   = s_data.buffer_free;
        case (s_data.usb_status)
            ifa_pkg::USB_GONE:    q_item.kind = ifa_pkg::KIND_GONE;
            ifa_pkg::USB_SKIPPED: q_item.kind = ifa_pkg::KIND_NOP;
            ifa_pkg::USB_ERROR:   q_item.kind = ifa_pkg::KIND_ERR;
            ifa_pkg::USB_DONE: begin
                if (s_data.packet_bytes == '0) begin
                    q_item.kind = ifa_pkg::KIND_NOP;
                end else if (bad_len) begin
                    q_item.kind = ifa_pkg::KIND_ERR;
                end else begin
                    q_item.kind = ifa_pkg::KIND_DATA;
                end
            end
            default:              q_item.kind = ifa_pkg::KIND_NOP;
        endcase
    end

endmodule

// ===== hdl/ifa_queue.sv =====
// Short queue of classified descriptors between front and back.
module ifa_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  ifa_pkg::item_t push_item,
    output logic           full,
    input  logic           pop,
    output logic           q_valid,
    output ifa_pkg::item_t q_item
);

    localparam int PtrW = $clog2(ifa_pkg::QUEUE_DEPTH);
    localparam logic [PtrW:0] Depth = (PtrW + 1)'(ifa_pkg::QUEUE_DEPTH);
    localparam logic [PtrW-1:0] LastPtr = PtrW'(ifa_pkg::QUEUE_DEPTH - 1);

    ifa_pkg::item_t entry_reg [ifa_pkg::QUEUE_DEPTH];
    logic [PtrW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [PtrW:0]   count_reg, count_next;

    assign full    = (count_reg == Depth);
    assign q_valid = (count_reg != '0);
    assign q_item  = entry_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    // Pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == LastPtr) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == LastPtr) ? '0 : rd_ptr_reg + 1'b1;
            end
        end
    end

    // Entry storage
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ===== hdl/ifa_back.sv =====
// Back end: frame state, append and frame end decisions, output register.
module ifa_back (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_we,
    input  logic [ifa_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [ifa_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    input  logic                              q_valid,
    input  ifa_pkg::item_t                    q_item,
    output logic                              q_pop,
    output logic                              m_valid,
    input  logic                              m_ready,
    output ifa_pkg::iso_out_t                 m_data
);

    logic                        streaming_reg, streaming_next;
    logic                        last_fid_reg, last_fid_next;
    logic                        skip_reg, skip_next;
    logic                        holding_reg, holding_next;
    logic [ifa_pkg::FILL_W-1:0]  fill_reg, fill_next;
    logic [ifa_pkg::FILL_W-1:0]  capacity_reg;
    logic                        out_valid_reg;
    ifa_pkg::iso_out_t           out_reg, out_next;

    logic                        new_frame, holding0, skip1;
    logic [ifa_pkg::FILL_W-1:0]  fill0;
    logic [ifa_pkg::FILL_W:0]    sum;

    assign q_pop   = q_valid && (!out_valid_reg || m_ready);
    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    // Frame bookkeeping for a data packet
    assign new_frame = (q_item.frame_tag != last_fid_reg);
    assign holding0  = holding_reg || new_frame;
    assign fill0     = new_frame ? '0 : fill_reg;
    assign skip1     = (new_frame ? q_item.error_bit : skip_reg) || q_item.error_bit;
    assign sum       = {1'b0, fill0} + (ifa_pkg::FILL_W + 1)'(q_item.payload_len);

    // Next state and result for the item at the head of the queue
    always_comb begin
        streaming_next = streaming_reg;
        last_fid_next  = last_fid_reg;
        skip_next      = skip_reg;
        holding_next   = holding_reg;
        fill_next      = fill_reg;
        out_next       = '0;
        if (q_item.kind == ifa_pkg::KIND_GONE) begin
            streaming_next = 1'b0;
            if (streaming_reg) begin
                out_next.event_res = ifa_pkg::EV_PAUSED;
            end
        end else if (streaming_reg) begin
            case (q_item.kind)
                ifa_pkg::KIND_ERR: skip_next = 1'b1;
                ifa_pkg::KIND_DATA: begin
                    last_fid_next = q_item.frame_tag;
                    if (new_frame && !holding_reg && !q_item.buffer_free) begin
                        skip_next          = 1'b1;
                        out_next.event_res = ifa_pkg::EV_UNDERFLOW;
                    end else if (!skip1 && holding0 && (sum > {1'b0, capacity_reg})) begin
                        skip_next          = 1'b1;
                        holding_next       = holding0;
                        fill_next          = fill0;
                        out_next.event_res = ifa_pkg::EV_OVERFLOW;
                    end else begin
                        holding_next = holding0;
                        fill_next    = fill0;
                        skip_next    = skip1;
                        if (!skip1) begin
                            if (!holding0) begin
                                skip_next = 1'b1;
                            end else begin
                                out_next.event_res    = ifa_pkg::EV_APPEND;
                                out_next.write_offset = fill0;
                                out_next.write_length = q_item.payload_len;
                                out_next.data_start   = q_item.header_length;
                                fill_next             = sum[ifa_pkg::FILL_W-1:0];
                            end
                        end
                        // End of frame with a held buffer
                        if (q_item.end_bit && holding0) begin
                            out_next.frame_end    = skip1 ? ifa_pkg::FE_DISCARD
                                                          : ifa_pkg::FE_GOOD;
                            out_next.frame_length = skip1 ? fill0
                                                          : sum[ifa_pkg::FILL_W-1:0];
                            holding_next          = 1'b0;
                            fill_next             = '0;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // State, configuration and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            streaming_reg <= 1'b0;
            last_fid_reg  <= 1'b0;
            skip_reg      <= 1'b0;
            holding_reg   <= 1'b0;
            fill_reg      <= '0;
            capacity_reg  <= ifa_pkg::CAPACITY_RESET;
            out_valid_reg <= 1'b0;
        end else begin
            if (q_pop) begin
                streaming_reg <= streaming_next;
                last_fid_reg  <= last_fid_next;
                skip_reg      <= skip_next;
                holding_reg   <= holding_next;
                fill_reg      <= fill_next;
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_we) begin
                case (cfg_index)
                    ifa_pkg::CFG_STREAM_ENABLE:  streaming_reg <= cfg_wdata[0];
                    ifa_pkg::CFG_FRAME_CAPACITY: capacity_reg  <= cfg_wdata;
                    default: ;
                endcase
            end
        end
    end

    // Result payload
    always_ff @(posedge aclk) begin
        if (q_pop) begin
            out_reg <= out_next;
        end
    end

endmodule

// ===== hdl/uvc_isoc_frame_assembler.sv =====
// Top level of the isochronous frame assembler.
//
// s_* carries one packet descriptor per transaction (USB status, length,
// payload header bits, buffer availability); m_* returns exactly one
// result per descriptor: an append command or an underflow, overflow or
// pause event, plus frame delivery or discard at end of frame.
// cfg_we/cfg_index/cfg_wdata write stream_enable (index 0) and
// frame_capacity (index 1); the user must write them only while the
// block is idle, which the block itself does not enforce.
// A descriptor taken on s_ready enters the queue, and its result is
// registered in the output register when the back end pops it; one
// descriptor per cycle is taken while m_ready is high.
// A two-entry queue separates classification from the frame state, and
// an output register holds a result while m_ready is low; under
// back-to-back traffic a stall on m_ready fills the queue and
// s_ready then stays low until the back end pops again.
// Reset clears streaming, frame id, skip, buffer and fill state and sets
// frame_capacity to its maximum; no result is pending after reset.
module uvc_isoc_frame_assembler #(
    parameter int MAX_PACKET_BYTES = 3072
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_we,
    input  logic [ifa_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ifa_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  ifa_pkg::iso_in_t               s_data,
    output logic                           m_valid,
    input  logic                           m_ready,
    output ifa_pkg::iso_out_t              m_data
);

    logic           q_full, q_push, q_pop, q_valid;
    ifa_pkg::item_t push_item, head_item;

    ifa_front #(
        .MAX_PACKET_BYTES(MAX_PACKET_BYTES)
    ) u_front (
        .s_data (s_data),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .q_full (q_full),
        .q_push (q_push),
        .q_item (push_item)
    );

    ifa_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_item(push_item),
        .full     (q_full),
        .pop      (q_pop),
        .q_valid  (q_valid),
        .q_item   (head_item)
    );

    ifa_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata),
        .q_valid  (q_valid),
        .q_item   (head_item),
        .q_pop    (q_pop),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

`ifndef ASSERT_OFF
    // The back end never consumes from an empty queue
    assert property (@(posedge aclk) disable iff (!aresetn) q_pop |-> q_valid)
        else $error("queue popped while empty");

    // Append fields are zero unless the event is an append
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.event_res != ifa_pkg::EV_APPEND) |->
        (m_data.write_length == '0 && m_data.write_offset == '0))
        else $error("append fields set without append event");

    // Frame length is zero when no frame ends
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.frame_end == ifa_pkg::FE_NONE) |-> m_data.frame_length == '0)
        else $error("frame length set without frame end");
`endif

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the isochronous frame assembler.
module tb;

    localparam int MAX_PACKET_BYTES = 3072;
    localparam int RANDOM_ITEMS     = 1350;
    localparam int CYCLE_LIMIT      = 200000;

    // Register write request for the config driver
    typedef struct packed {
        logic [ifa_pkg::CFG_IDX_W-1:0]  idx;
        logic [ifa_pkg::CFG_DATA_W-1:0] val;
    } reg_write_t;

    logic                           aclk      = 1'b0;
    logic                           aresetn   = 1'b0;
    logic                           cfg_we    = 1'b0;
    logic [ifa_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [ifa_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                           s_valid   = 1'b0;
    logic                           s_ready;
    ifa_pkg::iso_in_t               s_data    = '0;
    logic                           m_valid;
    logic                           m_ready   = 1'b0;
    ifa_pkg::iso_out_t              m_data;

    // Predicted frame state and configuration
    logic                       asm_streaming = 1'b0;
    logic                       asm_last_fid  = 1'b0;
    logic                       asm_skip      = 1'b0;
    logic                       asm_holding   = 1'b0;
    logic [ifa_pkg::FILL_W-1:0] asm_fill      = '0;
    logic [ifa_pkg::FILL_W-1:0] asm_capacity  = ifa_pkg::CAPACITY_RESET;

    ifa_pkg::iso_out_t expected_results[$];
    reg_write_t        pending_writes[$];
    reg_write_t        cur_write;
    ifa_pkg::iso_out_t mon_want;

    logic        steady = 1'b0;   // no idling on either side while set
    int          mismatches = 0;
    int          items_sent = 0;
    int          live_items = 0;
    int          results_checked = 0;
    int          frames_good = 0;
    int          frames_dropped = 0;
    int          random_phases = 0;
    int          ev_count[0:7];
    int unsigned cycle_count = 0;

    uvc_isoc_frame_assembler #(
        .MAX_PACKET_BYTES(MAX_PACKET_BYTES)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

    always #5 aclk = ~aclk;

    // Watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Frame assembly prediction for one packet descriptor
    function automatic ifa_pkg::iso_out_t assemble_packet(input ifa_pkg::iso_in_t d);
        ifa_pkg::iso_out_t            r;
        logic [ifa_pkg::FILL_W:0]     sum;
        logic [ifa_pkg::PBYTES_W-1:0] plen;
        r = '0;
        if (d.usb_status == ifa_pkg::USB_GONE) begin
            if (asm_streaming)
                r.event_res = ifa_pkg::EV_PAUSED;
            asm_streaming = 1'b0;
            return r;
        end
        if (!asm_streaming || d.usb_status == ifa_pkg::USB_SKIPPED)
            return r;
        if (d.usb_status == ifa_pkg::USB_ERROR) begin
            asm_skip = 1'b1;
            return r;
        end
        if (d.packet_bytes == '0)
            return r;
        // short or oversized packets count as bus errors
        if (d.packet_bytes < ifa_pkg::PBYTES_W'(d.header_length)
                || int'(d.packet_bytes) > MAX_PACKET_BYTES) begin
            asm_skip = 1'b1;
            return r;
        end
        // frame id toggle opens a new frame
        if (d.frame_tag != asm_last_fid) begin
            asm_last_fid = d.frame_tag;
            asm_skip     = d.error_bit;
            if (!asm_holding) begin
                if (d.buffer_free) begin
                    asm_holding = 1'b1;
                    asm_fill    = '0;
                end else begin
                    asm_skip    = 1'b1;
                    r.event_res = ifa_pkg::EV_UNDERFLOW;
                    return r;
                end
            end else begin
                asm_fill = '0;   // missed end of frame: rewind
            end
        end
        if (d.error_bit)
            asm_skip = 1'b1;
        // append payload
        if (!asm_skip) begin
            if (!asm_holding) begin
                asm_skip = 1'b1;
            end else begin
                plen = d.packet_bytes - ifa_pkg::PBYTES_W'(d.header_length);
                sum  = {1'b0, asm_fill} + (ifa_pkg::FILL_W + 1)'(plen);
                if (sum > {1'b0, asm_capacity}) begin
                    asm_skip    = 1'b1;
                    r.event_res = ifa_pkg::EV_OVERFLOW;
                    return r;
                end
                r.event_res    = ifa_pkg::EV_APPEND;
                r.write_offset = asm_fill;
                r.write_length = plen;
                r.data_start   = d.header_length;
                asm_fill       = sum[ifa_pkg::FILL_W-1:0];
            end
        end
        // end of frame
        if (d.end_bit && asm_holding) begin
            r.frame_end    = asm_skip ? ifa_pkg::FE_DISCARD : ifa_pkg::FE_GOOD;
            r.frame_length = asm_fill;
            asm_holding    = 1'b0;
            asm_fill       = '0;
        end
        return r;
    endfunction

    function automatic ifa_pkg::iso_in_t make_desc(input logic [ifa_pkg::STATUS_W-1:0] st,
                                                   input int pb, input int hl,
                                                   input int fid, input int err,
                                                   input int eof, input int bfree);
        ifa_pkg::iso_in_t d;
        d.usb_status    = st;
        d.packet_bytes  = ifa_pkg::PBYTES_W'(pb);
        d.header_length = ifa_pkg::HLEN_W'(hl);
        d.frame_tag     = fid[0];
        d.error_bit     = err[0];
        d.end_bit       = eof[0];
        d.buffer_free   = bfree[0];
        return d;
    endfunction

    function automatic ifa_pkg::iso_in_t random_desc();
        logic [ifa_pkg::STATUS_W-1:0] st;
        st = ($urandom_range(0, 7) == 0) ? ifa_pkg::USB_GONE
                                         : ifa_pkg::STATUS_W'($urandom_range(0, 2));
        return make_desc(st, $urandom_range(0, 4095), $urandom_range(0, 255),
                         $urandom_range(0, 1), $urandom_range(0, 1),
                         $urandom_range(0, 1), $urandom_range(0, 1));
    endfunction

    function automatic void check_field(input string fname,
                                        input logic [ifa_pkg::FILL_W-1:0] want,
                                        input logic [ifa_pkg::FILL_W-1:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0d, got %0d", fname, want, got);
            mismatches++;
        end
    endfunction

    // Config driver: one write per edge
    always @(posedge aclk) begin
        if (pending_writes.size() != 0) begin
            cur_write = pending_writes.pop_front();
            cfg_we    <= 1'b1;
            cfg_index <= cur_write.idx;
            cfg_wdata <= cur_write.val;
        end else begin
            cfg_we <= 1'b0;
        end
    end

    // Result checker and receiver stalls
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                $error("result transaction with nothing expected: event_res %0d",
                       m_data.event_res);
                mismatches++;
            end else begin
                mon_want = expected_results.pop_front();
                check_field("event_res", ifa_pkg::FILL_W'(mon_want.event_res),
                            ifa_pkg::FILL_W'(m_data.event_res));
                check_field("write_offset", mon_want.write_offset, m_data.write_offset);
                check_field("write_length", ifa_pkg::FILL_W'(mon_want.write_length),
                            ifa_pkg::FILL_W'(m_data.write_length));
                check_field("data_start", ifa_pkg::FILL_W'(mon_want.data_start),
                            ifa_pkg::FILL_W'(m_data.data_start));
                check_field("frame_end", ifa_pkg::FILL_W'(mon_want.frame_end),
                            ifa_pkg::FILL_W'(m_data.frame_end));
                check_field("frame_length", mon_want.frame_length, m_data.frame_length);
                results_checked++;
                ev_count[mon_want.event_res]++;
                if (mon_want.frame_end == ifa_pkg::FE_GOOD)
                    frames_good++;
                else if (mon_want.frame_end == ifa_pkg::FE_DISCARD)
                    frames_dropped++;
            end
        end
        m_ready <= steady || ($urandom_range(0, 99) >= 12);
    end

    // Send one descriptor; prediction is taken at the accepting edge
    task automatic send_desc(input ifa_pkg::iso_in_t d);
        while (!steady && $urandom_range(0, 99) < 12) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= d;
        do @(posedge aclk); while (!s_ready);
        if (asm_streaming)
            live_items++;
        expected_results.push_back(assemble_packet(d));
        items_sent++;
    endtask

    // Stop sending and wait for every outstanding result
    task automatic drain_results();
        s_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge aclk);
    endtask

    // Queue one register write; the block is idle, so the prediction moves now
    task automatic write_reg(input logic [ifa_pkg::CFG_IDX_W-1:0] idx,
                             input logic [ifa_pkg::CFG_DATA_W-1:0] val);
        reg_write_t w;
        w.idx = idx;
        w.val = val;
        if (idx == ifa_pkg::CFG_STREAM_ENABLE)
            asm_streaming = val[0];
        else
            asm_capacity = val;
        pending_writes.push_back(w);
        while (pending_writes.size() != 0)
            @(posedge aclk);
        @(posedge aclk);
    endtask

    // Ignored while idle, data without buffer, good and discarded frames
    task automatic test_basic_frames();
        send_desc(make_desc(ifa_pkg::USB_DONE, 100, 12, 1, 0, 0, 1));
        drain_results();
        write_reg(ifa_pkg::CFG_STREAM_ENABLE, 24'd1);
        send_desc(make_desc(ifa_pkg::USB_DONE, 50, 2, 0, 0, 0, 1));
        send_desc(make_desc(ifa_pkg::USB_DONE, 40, 2, 0, 0, 1, 1));
        send_desc(make_desc(ifa_pkg::USB_DONE, 3072, 255, 1, 0, 0, 1));
        send_desc(make_desc(ifa_pkg::USB_DONE, 12, 12, 1, 0, 0, 1));
        send_desc(make_desc(ifa_pkg::USB_DONE, 0, 0, 1, 0, 0, 1));
        send_desc(make_desc(ifa_pkg::USB_SKIPPED, 500, 12, 1, 0, 0, 1));
        send_desc(make_desc(ifa_pkg::USB_DONE, 1, 0, 1, 0, 1, 1));
        send_desc(make_desc(ifa_pkg::USB_DONE, 200, 12, 0, 0, 0, 1));
        send_desc(make_desc(ifa_pkg::USB_ERROR, 200, 12, 0, 0, 0, 1));
        send_desc(make_desc(ifa_pkg::USB_DONE, 100, 12, 0, 0, 1, 1));
    endtask

    // Short/oversized packets, underflow, rewind and device loss
    task automatic test_bad_packets();
        send_desc(make_desc(ifa_pkg::USB_DONE, 10, 20, 1, 0, 0, 1));
        send_desc(make_desc(ifa_pkg::USB_DONE, 3073, 12, 1, 0, 0, 1));
        send_desc(make_desc(ifa_pkg::USB_DONE, 4095, 255, 1, 1, 1, 1));
        send_desc(make_desc(ifa_pkg::USB_DONE, 100, 12, 1, 0, 0, 0));
        send_desc(make_desc(ifa_pkg::USB_DONE, 100, 12, 0, 1, 0, 1));
        send_desc(make_desc(ifa_pkg::USB_DONE, 100, 12, 1, 0, 0, 1));
        send_desc(make_desc(ifa_pkg::USB_DONE, 100, 12, 1, 0, 0, 1));
        send_desc(make_desc(ifa_pkg::USB_GONE, 0, 0, 0, 0, 0, 0));
        send_desc(make_desc(ifa_pkg::USB_GONE, 4095, 255, 1, 1, 1, 1));
    endtask

    // Zero and exact capacity, then streaming turned off by a write
    task automatic test_capacity_edges();
        drain_results();
        write_reg(ifa_pkg::CFG_FRAME_CAPACITY, 24'd0);
        write_reg(ifa_pkg::CFG_STREAM_ENABLE, 24'd1);
        send_desc(make_desc(ifa_pkg::USB_DONE, 50, 12, 0, 0, 0, 1));
        send_desc(make_desc(ifa_pkg::USB_DONE, 12, 12, 0, 0, 1, 1));
        drain_results();
        write_reg(ifa_pkg::CFG_FRAME_CAPACITY, 24'd100);
        send_desc(make_desc(ifa_pkg::USB_DONE, 112, 12, 1, 0, 0, 1));
        send_desc(make_desc(ifa_pkg::USB_DONE, 13, 12, 1, 0, 1, 1));
        drain_results();
        write_reg(ifa_pkg::CFG_STREAM_ENABLE, 24'hFFFFFE);
        send_desc(make_desc(ifa_pkg::USB_DONE, 64, 4, 0, 0, 1, 1));
    endtask

    // One well-formed frame with random content and occasional damage
    task automatic send_random_frame();
        ifa_pkg::iso_in_t d;
        int               n;
        int               hl;
        int               pb;
        int               span;
        int               fid;
        fid = asm_last_fid ? 0 : 1;
        n   = $urandom_range(1, 8);
        for (int k = 0; k < n; k++) begin
            if (!asm_streaming)
                break;
            hl   = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255) : $urandom_range(2, 12);
            span = ($urandom_range(0, 3) == 0) ? MAX_PACKET_BYTES - hl : 600;
            pb   = hl + $urandom_range(0, span);
            d = make_desc(ifa_pkg::USB_DONE, pb, hl, fid, int'($urandom_range(0, 29) == 0),
                          int'((k == n - 1) ? ($urandom_range(0, 9) != 0)
                                            : ($urandom_range(0, 19) == 0)),
                          int'($urandom_range(0, 9) != 0));
            case ($urandom_range(0, 29))
                0: d.usb_status = ifa_pkg::USB_ERROR;
                1: d.usb_status = ifa_pkg::USB_SKIPPED;
                2: d.packet_bytes = '0;
                3: if (hl != 0) d.packet_bytes = ifa_pkg::PBYTES_W'($urandom_range(0, hl - 1));
                4: d.packet_bytes = ifa_pkg::PBYTES_W'($urandom_range(MAX_PACKET_BYTES + 1,
                                                                      4095));
                default: ;
            endcase
            send_desc(d);
        end
    endtask

    // Phases of random frames under different capacities
    task automatic test_random_traffic(input int target);
        int                             phase_start;
        logic [ifa_pkg::CFG_DATA_W-1:0] cap;
        logic [ifa_pkg::CFG_DATA_W-1:0] en;
        while (live_items < target) begin
            drain_results();
            case (random_phases % 4)
                0: cap = ifa_pkg::CAPACITY_RESET;
                1: cap = 24'd1;
                2: cap = ifa_pkg::CFG_DATA_W'($urandom_range(200, 8000));
                default: cap = ifa_pkg::CFG_DATA_W'($urandom_range(1, 24'hFFFFFF));
            endcase
            steady = (random_phases == 2);
            en     = ifa_pkg::CFG_DATA_W'($urandom());
            en[0]  = 1'b1;
            write_reg(ifa_pkg::CFG_FRAME_CAPACITY, cap);
            write_reg(ifa_pkg::CFG_STREAM_ENABLE, en);
            phase_start = live_items;
            while (asm_streaming && live_items - phase_start < 180 && live_items < target) begin
                if ($urandom_range(0, 14) == 0)
                    send_desc(random_desc());
                else
                    send_random_frame();
            end
            random_phases++;
        end
        drain_results();
        steady = 1'b0;
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        test_basic_frames();
        test_bad_packets();
        test_capacity_edges();
        test_random_traffic(RANDOM_ITEMS);
        repeat (4) @(posedge aclk);
        if (expected_results.size() != 0) begin
            $error("%0d expected results never arrived", expected_results.size());
            mismatches++;
        end
        $display("Covered %0d descriptors (%0d while streaming), %0d results checked, %0d phases",
                 items_sent, live_items, results_checked, random_phases);
        $display({"Frames good %0d / discarded %0d; append %0d, underflow %0d, ",
                  "overflow %0d, pause %0d"},
                 frames_good, frames_dropped, ev_count[ifa_pkg::EV_APPEND],
                 ev_count[ifa_pkg::EV_UNDERFLOW], ev_count[ifa_pkg::EV_OVERFLOW],
                 ev_count[ifa_pkg::EV_PAUSED]);
        if (mismatches == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// ===== uvc_isoc_frame_assembler.f =====
hdl/ifa_pkg.sv
hdl/ifa_front.sv
hdl/ifa_queue.sv
hdl/ifa_back.sv
hdl/uvc_isoc_frame_assembler.sv
tb/tb.sv
